FILE: hdl/dofs_pkg.sv
`default_nettype none

package dofs_pkg;

  // Size of the seen-bitmaps and width of packet offsets
  localparam int CODE_COUNT  = 256;
  localparam int OFFSET_BITS = 11;
  localparam int CODE_W      = $clog2(CODE_COUNT);

  // Option codes with fixed meaning
  localparam logic [7:0] CODE_PAD = 8'h00;
  localparam logic [7:0] CODE_END = 8'hFF;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_MAIN   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_VENDOR = 1'b1;

  // Reset value of both highest-code registers
  localparam logic [7:0] MAX_CODE_RESET = 8'd254;

  // Parser phase
  typedef enum logic [1:0] {
    PH_CODE,
    PH_LEN,
    PH_VALUE,
    PH_STOP
  } phase_t;

  // One input item
  typedef struct packed {
    logic [7:0]             data_byte;
    logic [OFFSET_BITS-1:0] byte_offset;
    logic                   field_first;
    logic                   field_final;
    logic                   packet_first;
    logic                   table_select;
  } item_t;

  // One result item
  typedef struct packed {
    logic                   found_table;
    logic [7:0]             found_code;
    logic [OFFSET_BITS-1:0] found_offset;
    logic [7:0]             found_length;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/dofs_if.sv
`default_nettype none

// Byte stream channel
interface dofs_in_if import dofs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [7:0]             data_byte;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic                   field_first;
  logic                   field_final;
  logic                   packet_first;
  logic                   table_select;

  modport source (output valid, data_byte, byte_offset, field_first, field_final,
                  packet_first, table_select, input ready);
  modport sink (input valid, data_byte, byte_offset, field_first, field_final,
                packet_first, table_select, output ready);
endinterface

// Found-option channel
interface dofs_out_if import dofs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   found_table;
  logic [7:0]             found_code;
  logic [OFFSET_BITS-1:0] found_offset;
  logic [7:0]             found_length;

  modport source (output valid, found_table, found_code, found_offset, found_length,
                  input ready);
  modport sink (input valid, found_table, found_code, found_offset, found_length,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/dofs_in_stage.sv
`default_nettype none

module dofs_in_stage import dofs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  dofs_in_if.sink    byte_ch,
  input  wire logic  advance,
  output item_t      item,
  output logic       item_valid
);

  logic in_ready;

  // Register frees up when empty or when its item moves on this cycle
  assign in_ready      = !item_valid || advance;
  assign byte_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= byte_ch.valid;
    end
  end

  // Payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && byte_ch.valid) begin
      item.data_byte    <= byte_ch.data_byte;
      item.byte_offset  <= byte_ch.byte_offset;
      item.field_first  <= byte_ch.field_first;
      item.field_final  <= byte_ch.field_final;
      item.packet_first <= byte_ch.packet_first;
      item.table_select <= byte_ch.table_select;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dofs_parser.sv
`default_nettype none

module dofs_parser import dofs_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [7:0]               cfg_data,
  input  wire item_t                    item,
  input  wire logic                     advance,
  output logic                          res_valid,
  output result_t                       res
);

  localparam logic [CODE_W:0] CODE_LIMIT = (CODE_W+1)'(CODE_COUNT);

  logic [7:0]             max_main;
  logic [7:0]             max_vendor;
  logic [CODE_COUNT-1:0]  seen_main;
  logic [CODE_COUNT-1:0]  seen_vendor;
  phase_t                 phase;
  logic [7:0]             bytes_left;
  logic [7:0]             held_code;
  logic [OFFSET_BITS-1:0] held_offset;
  logic [7:0]             held_length;
  logic                   will_record;

  phase_t                 phase_eff;
  phase_t                 phase_next;
  logic [7:0]             left_eff;
  logic [7:0]             left_dec;
  logic                   will_eff;
  logic                   finish;
  logic [CODE_COUNT-1:0]  seen_main_eff;
  logic [CODE_COUNT-1:0]  seen_vendor_eff;
  logic [CODE_W-1:0]      code_idx;
  logic                   code_known;
  logic                   seen_bit;
  logic                   hit;
  logic [CODE_COUNT-1:0]  set_vec;
  logic [7:0]             max_sel;
  logic [7:0]             bytes_left_next;
  logic [7:0]             held_code_next;
  logic [OFFSET_BITS-1:0] held_offset_next;
  logic [7:0]             held_length_next;
  logic                   will_record_next;
  logic [CODE_COUNT-1:0]  seen_main_next;
  logic [CODE_COUNT-1:0]  seen_vendor_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_main   <= MAX_CODE_RESET;
      max_vendor <= MAX_CODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_MAIN:   max_main   <= cfg_data;
        CFG_MAX_VENDOR: max_vendor <= cfg_data;
        default: ;
      endcase
    end
  end

  // Field start resets the parse state before the byte is handled
  assign phase_eff       = item.field_first ? PH_CODE : phase;
  assign left_eff        = item.field_first ? 8'd0 : bytes_left;
  assign will_eff        = item.field_first ? 1'b0 : will_record;
  assign left_dec        = left_eff - 8'd1;
  // Packet start clears the bitmaps before the lookup
  assign seen_main_eff   = item.packet_first ? '0 : seen_main;
  assign seen_vendor_eff = item.packet_first ? '0 : seen_vendor;

  // Next phase
  always_comb begin
    phase_next = phase_eff;
    finish     = 1'b0;
    unique case (phase_eff)
      PH_CODE: begin
        if (item.data_byte == CODE_END) begin
          phase_next = PH_STOP;
        end else if (item.data_byte != CODE_PAD) begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        if (item.data_byte == 8'd0) begin
          finish     = 1'b1;
          phase_next = PH_CODE;
        end else begin
          phase_next = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (left_dec == 8'd0) begin
          finish     = 1'b1;
          phase_next = PH_CODE;
        end
      end
      PH_STOP: ;
      default: ;
    endcase
    if (item.field_final) begin
      phase_next = PH_CODE;
    end
  end

  // Duplicate check against the bitmap of the completing byte's table
  assign code_idx   = held_code[CODE_W-1:0];
  assign code_known = {1'b0, held_code} < CODE_LIMIT;
  assign seen_bit   = item.table_select ? seen_vendor_eff[code_idx]
                                        : seen_main_eff[code_idx];
  assign hit        = finish && will_eff && code_known && !seen_bit;
  assign set_vec    = hit ? (CODE_COUNT'(1) << code_idx) : '0;
  assign max_sel    = item.table_select ? max_vendor : max_main;

  // Held option fields and bitmap updates
  always_comb begin
    bytes_left_next  = left_eff;
    held_code_next   = held_code;
    held_offset_next = held_offset;
    held_length_next = held_length;
    will_record_next = will_eff;
    unique case (phase_eff)
      PH_CODE: begin
        if (item.data_byte != CODE_PAD && item.data_byte != CODE_END) begin
          held_code_next   = item.data_byte;
          held_offset_next = item.byte_offset;
          will_record_next = (item.data_byte <= max_sel) &&
                             ({1'b0, item.data_byte} < CODE_LIMIT);
        end
      end
      PH_LEN: begin
        held_length_next = item.data_byte;
        bytes_left_next  = item.data_byte;
      end
      PH_VALUE: bytes_left_next = left_dec;
      PH_STOP: ;
      default: ;
    endcase
    if (item.field_final) begin
      will_record_next = 1'b0;
      bytes_left_next  = 8'd0;
    end
    seen_main_next   = seen_main_eff   | (item.table_select ? '0 : set_vec);
    seen_vendor_next = seen_vendor_eff | (item.table_select ? set_vec : '0);
  end

  // Result of this byte
  assign res_valid        = hit;
  assign res.found_table  = item.table_select;
  assign res.found_code   = held_code;
  assign res.found_offset = held_offset;
  assign res.found_length = (phase_eff == PH_LEN) ? item.data_byte : held_length;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_CODE;
      bytes_left  <= '0;
      held_code   <= '0;
      held_offset <= '0;
      held_length <= '0;
      will_record <= 1'b0;
      seen_main   <= '0;
      seen_vendor <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      held_code   <= held_code_next;
      held_offset <= held_offset_next;
      held_length <= held_length_next;
      will_record <= will_record_next;
      seen_main   <= seen_main_next;
      seen_vendor <= seen_vendor_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dofs_out_stage.sv
`default_nettype none

module dofs_out_stage import dofs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     advance,
  input  wire logic     res_valid,
  input  wire result_t  res,
  output logic          space,
  dofs_out_if.source    found_ch
);

  logic    out_valid;
  result_t out_res;

  // Room for a new result when empty or when the held one is taken now
  assign space = !out_valid || found_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (found_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign found_ch.valid        = out_valid;
  assign found_ch.found_table  = out_res.found_table;
  assign found_ch.found_code   = out_res.found_code;
  assign found_ch.found_offset = out_res.found_offset;
  assign found_ch.found_length = out_res.found_length;

endmodule

`default_nettype wire

FILE: hdl/dhcp_option_field_scanner_unit.sv
// A found option's completing byte is held in the input register; once it advances
//   through the parser, the result is held in the result register that drives found_ch.
// Throughput: one byte per cycle while the result side keeps up; one parse step
//   between the input register and the result register sets this.
// Reset (rst, synchronous, active high): parser back to expecting a code, both
//   seen-bitmaps cleared, highest known codes back to 254, both registers empty.
`default_nettype none

module dhcp_option_field_scanner_unit import dofs_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  dofs_in_if.sink                      byte_ch,
  dofs_out_if.source                   found_ch,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [7:0]              cfg_data
);

  item_t   item;
  logic    item_valid;
  logic    space;
  logic    advance;
  logic    res_valid;
  result_t res;

  // Byte moves through the parser when the result register has room
  assign advance = item_valid && space;

  dofs_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  dofs_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  dofs_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .found_ch  (found_ch)
  );

  // Input side stalls only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (byte_ch.valid && !byte_ch.ready) |-> (found_ch.valid && !found_ch.ready))
    else $error("input stalled without a blocked result");

  // A found option always reaches the result register
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid) |=> found_ch.valid)
    else $error("found option lost");

  // Pad and end codes are never reported
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    found_ch.valid |-> (found_ch.found_code != CODE_PAD && found_ch.found_code != CODE_END))
    else $error("reported pad or end code");

endmodule

`default_nettype wire

FILE: bench/dhcp_option_field_scanner_unit_tb.sv
`default_nettype none

module dhcp_option_field_scanner_unit_tb import dofs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  // Keeps its own copy of the parser state and the expected found options
  class found_option_checker;
    result_t                expected_found[$];
    int                     mismatches;
    bit                     seen[2][CODE_COUNT];
    logic [7:0]             max_code[2];
    phase_t                 phase;
    logic [7:0]             left;
    logic [7:0]             code;
    logic [OFFSET_BITS-1:0] code_off;
    logic [7:0]             len;
    bit                     will_report;

    function new();
      mismatches  = 0;
      max_code[0] = MAX_CODE_RESET;
      max_code[1] = MAX_CODE_RESET;
      foreach (seen[t, c]) seen[t][c] = 1'b0;
      phase       = PH_CODE;
      left        = '0;
      code        = '0;
      code_off    = '0;
      len         = '0;
      will_report = 1'b0;
    endfunction

    function void set_limit(logic [CFG_IDX_BITS-1:0] idx, logic [7:0] val);
      if (idx == CFG_MAX_MAIN) max_code[0] = val;
      else if (idx == CFG_MAX_VENDOR) max_code[1] = val;
    endfunction

    // Option complete: report it once per packet and table
    function void close_option(logic tbl);
      result_t r;
      phase = PH_CODE;
      if (!will_report || int'(code) >= CODE_COUNT) return;
      if (seen[tbl][code]) return;
      seen[tbl][code] = 1'b1;
      r.found_table  = tbl;
      r.found_code   = code;
      r.found_offset = code_off;
      r.found_length = len;
      expected_found.push_back(r);
    endfunction

    function void scan_byte(item_t it);
      if (it.packet_first) foreach (seen[t, c]) seen[t][c] = 1'b0;
      if (it.field_first) begin
        phase       = PH_CODE;
        will_report = 1'b0;
        left        = '0;
      end
      case (phase)
        PH_CODE: begin
          if (it.data_byte == CODE_END) begin
            phase = PH_STOP;
          end else if (it.data_byte != CODE_PAD) begin
            code        = it.data_byte;
            code_off    = it.byte_offset;
            will_report = (it.data_byte <= max_code[it.table_select]) &&
                          (int'(it.data_byte) < CODE_COUNT);
            phase       = PH_LEN;
          end
        end
        PH_LEN: begin
          len  = it.data_byte;
          left = it.data_byte;
          if (it.data_byte == 8'd0) close_option(it.table_select);
          else phase = PH_VALUE;
        end
        PH_VALUE: begin
          left = left - 8'd1;
          if (left == 8'd0) close_option(it.table_select);
        end
        default: ;
      endcase
      if (it.field_final) begin
        phase       = PH_CODE;
        will_report = 1'b0;
        left        = '0;
      end
    endfunction

    function void compare_found(result_t got);
      result_t exp;
      if (expected_found.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t unexpected option: table %0d code %0d offset %0d length %0d", $time,
                   got.found_table, got.found_code, got.found_offset, got.found_length);
        return;
      end
      exp = expected_found.pop_front();
      if (got.found_table !== exp.found_table || got.found_code !== exp.found_code ||
          got.found_offset !== exp.found_offset || got.found_length !== exp.found_length) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t option mismatch: expected table %0d code %0d offset %0d length %0d,",
                   $time, exp.found_table, exp.found_code, exp.found_offset, exp.found_length,
                   " got table %0d code %0d offset %0d length %0d",
                   got.found_table, got.found_code, got.found_offset, got.found_length);
      end
    endfunction

    function int pending();
      return expected_found.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [7:0]              cfg_data;

  dofs_in_if  byte_ch ();
  dofs_out_if found_ch ();

  dhcp_option_field_scanner_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .found_ch  (found_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  found_option_checker scan_chk = new();

  int                     tx_idle_pct = 34;
  int                     rx_idle_pct = 34;
  bit                     hold_req    = 1'b0;
  int                     hold_left   = 0;
  int                     items_sent  = 0;
  int                     cycle_count = 0;
  logic [7:0]             lim_main    = MAX_CODE_RESET;
  logic [7:0]             lim_vendor  = MAX_CODE_RESET;
  logic [OFFSET_BITS-1:0] pkt_off;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL dhcp_option_field_scanner_unit");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      found_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      found_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      found_ch.ready <= 1'b0;
    end else begin
      found_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor both channels
  always @(posedge clk) begin
    item_t   it;
    result_t got;
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready) begin
        it.data_byte    = byte_ch.data_byte;
        it.byte_offset  = byte_ch.byte_offset;
        it.field_first  = byte_ch.field_first;
        it.field_final  = byte_ch.field_final;
        it.packet_first = byte_ch.packet_first;
        it.table_select = byte_ch.table_select;
        scan_chk.scan_byte(it);
      end
      if (found_ch.valid && found_ch.ready) begin
        got.found_table  = found_ch.found_table;
        got.found_code   = found_ch.found_code;
        got.found_offset = found_ch.found_offset;
        got.found_length = found_ch.found_length;
        scan_chk.compare_found(got);
      end
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic [OFFSET_BITS-1:0] offs,
                           input logic first, input logic last, input logic pkt,
                           input logic tbl);
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid        <= 1'b1;
    byte_ch.data_byte    <= data;
    byte_ch.byte_offset  <= offs;
    byte_ch.field_first  <= first;
    byte_ch.field_final  <= last;
    byte_ch.packet_first <= pkt;
    byte_ch.table_select <= tbl;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every expected option has come out
  task automatic wait_drain();
    byte_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (scan_chk.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limits(input logic [7:0] main_max, input logic [7:0] vendor_max);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_MAIN;
    cfg_data  <= main_max;
    @(posedge clk);
    cfg_index <= CFG_MAX_VENDOR;
    cfg_data  <= vendor_max;
    @(posedge clk);
    cfg_we <= 1'b0;
    scan_chk.set_limit(CFG_MAX_MAIN, main_max);
    scan_chk.set_limit(CFG_MAX_VENDOR, vendor_max);
    lim_main   = main_max;
    lim_vendor = vendor_max;
  endtask

  // Codes: pads, end codes, random codes, codes around the table limit, a small set that repeats
  function automatic logic [7:0] pick_code(logic tbl);
    int r;
    int lim;
    r   = $urandom_range(99);
    lim = tbl ? lim_vendor : lim_main;
    if (r < 5) return CODE_PAD;
    if (r < 9) return CODE_END;
    if (r < 22) return 8'($urandom_range(254, 1));
    if (r < 32) begin
      lim = lim + int'($urandom_range(2)) - 1;
      if (lim < 1) lim = 1;
      if (lim > 254) lim = 254;
      return 8'(lim);
    end
    return 8'($urandom_range(16, 1));
  endfunction

  // Lengths: mostly short, now and then the longest
  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 8'd0;
    if (r < 93) return 8'($urandom_range(6, 1));
    if (r < 99) return 8'($urandom_range(40, 7));
    return 8'd255;
  endfunction

  task automatic send_field(input logic pkt_start, input logic use_first);
    logic [7:0] fbytes[$];
    logic       tbl;
    int         nopts;
    int         cut;
    logic [7:0] c;
    logic [7:0] n;
    tbl   = 1'($urandom_range(1));
    nopts = $urandom_range(8, 1);
    for (int i = 0; i < nopts; i++) begin
      c = pick_code(tbl);
      fbytes.push_back(c);
      if (c == CODE_END) begin
        repeat ($urandom_range(3)) fbytes.push_back(8'($urandom_range(255)));
        break;
      end
      if (c != CODE_PAD) begin
        n = pick_len();
        fbytes.push_back(n);
        repeat (n) fbytes.push_back(8'($urandom_range(255)));
      end
    end
    // Some fields end early, cutting an option short
    cut = ($urandom_range(9) == 0) ? $urandom_range(fbytes.size(), 1) : fbytes.size();
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(19) == 0) tbl = ~tbl;
      send_byte(fbytes[i], pkt_off, use_first && (i == 0), i == cut - 1,
                (pkt_start && (i == 0)) || ($urandom_range(49) == 0), tbl);
      pkt_off++;
    end
  endtask

  task automatic send_packet();
    int nf;
    pkt_off = OFFSET_BITS'($urandom_range(2047));
    nf      = $urandom_range(3, 1);
    for (int f = 0; f < nf; f++)
      send_field(f == 0, (f == 0) || ($urandom_range(4) != 0));
    // Noise: bytes with random content and flags
    if ($urandom_range(11) == 0)
      repeat ($urandom_range(4, 1))
        send_byte(8'($urandom_range(255)), OFFSET_BITS'($urandom_range(2047)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
  endtask

  task automatic run_random(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) send_packet();
    wait_drain();
  endtask

  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_MAX_MAIN;
    cfg_data             <= '0;
    byte_ch.valid        <= 1'b0;
    byte_ch.data_byte    <= '0;
    byte_ch.byte_offset  <= '0;
    byte_ch.field_first  <= 1'b0;
    byte_ch.field_final  <= 1'b0;
    byte_ch.packet_first <= 1'b0;
    byte_ch.table_select <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pad, then a zero-length option
    send_byte(CODE_PAD, 11'd0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_byte(8'd1,     11'd1, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(8'd0,     11'd2, 1'b0, 1'b0, 1'b0, 1'b0);
    // Highest code in the vendor table
    send_byte(8'd254,   11'd3, 1'b0, 1'b0, 1'b0, 1'b1);
    send_byte(8'd2,     11'd4, 1'b0, 1'b0, 1'b0, 1'b1);
    send_byte(8'hff,    11'd5, 1'b0, 1'b0, 1'b0, 1'b1);
    send_byte(8'h00,    11'd6, 1'b0, 1'b0, 1'b0, 1'b1);
    // Duplicate is skipped
    send_byte(8'd1,     11'd7, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(8'd0,     11'd8, 1'b0, 1'b0, 1'b0, 1'b0);
    // Table changes mid-option
    send_byte(8'd9,     11'd9, 1'b0, 1'b0, 1'b0, 1'b1);
    send_byte(8'd1,     11'd10, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(8'h5a,    11'd11, 1'b0, 1'b0, 1'b0, 1'b0);
    // Packet start mid-option: bitmaps clear, option still reported
    send_byte(8'd1,     11'd12, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(8'd1,     11'd13, 1'b0, 1'b0, 1'b1, 1'b0);
    send_byte(8'h3c,    11'd14, 1'b0, 1'b0, 1'b0, 1'b0);
    // End code, ignored bytes, field end
    send_byte(CODE_END, 11'd15, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(8'd3,     11'd16, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(8'd0,     11'd17, 1'b0, 1'b1, 1'b0, 1'b0);
    // Scanned as a new field without field_first; cut off by the field end
    send_byte(8'd7,     11'd2045, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(8'd4,     11'd2046, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(8'h11,    11'd2047, 1'b0, 1'b1, 1'b0, 1'b0);
    // One-byte field, then a field start that aborts an option
    send_byte(8'd8,     11'd0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_byte(8'd8,     11'd1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_byte(8'd2,     11'd2, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(8'd6,     11'd3, 1'b1, 1'b0, 1'b0, 1'b0);
    send_byte(8'd0,     11'd4, 1'b0, 1'b1, 1'b0, 1'b0);
    wait_drain();

    run_random(215);
    write_limits(8'd0, 8'd254);
    run_random(240);
    write_limits(8'd254, 8'd0);
    run_random(240);

    // No idling, and a long hold-off on the result side so the input backs up
    write_limits(8'd12, 8'd40);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    run_random(240);
    tx_idle_pct = 34;
    rx_idle_pct = 34;

    write_limits(8'($urandom_range(254)), 8'($urandom_range(254)));
    run_random(240);
    write_limits(8'd254, 8'd254);
    run_random(240);

    if (scan_chk.mismatches == 0 && scan_chk.pending() == 0) begin
      $display("PASS dhcp_option_field_scanner_unit");
    end else begin
      $display("FAIL dhcp_option_field_scanner_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire
